### rtl/yuv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB converter package
// Shared types, widths and fixed-point coefficients of the converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    // Fraction bits of the unsigned fixed-point color coefficients.
    localparam int COEF_FRAC_BITS = 16;

    // Every coefficient is below 2.0, so one integer bit is enough.
    localparam int COEF_W = COEF_FRAC_BITS + 1;

    // Signed coefficient times signed 9-bit chroma offset.
    localparam int TERM_W = COEF_W + 1 + 9;

    // Luma scaled by 2^F plus a chroma term, with sign headroom.
    localparam int ACC_W = TERM_W + 1;

    // Coefficients rounded to nearest from their decimal values (units of 1e-5).
    localparam logic [COEF_W-1:0] K_RV =
        COEF_W'(((64'd140200 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] K_GU =
        COEF_W'(((64'd34414 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] K_GV =
        COEF_W'(((64'd71414 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] K_BU =
        COEF_W'(((64'd177200 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);

    // Byte positions within one packed group.
    localparam logic [1:0] PHASE_Y0 = 2'd0;
    localparam logic [1:0] PHASE_U  = 2'd1;
    localparam logic [1:0] PHASE_Y1 = 2'd2;
    localparam logic [1:0] PHASE_V  = 2'd3;

    // Depth of the group queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One complete YUYV group handed from the front to the back.
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_end;
    } group_t;

endpackage : yuv2rgb_pkg
`default_nettype wire

### rtl/yuyv_to_rgb_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB converter
// Converts a packed YUYV 4:2:2 byte stream to RGB888 pixels, full-range BT.601.
// ----------------------------------------------------------------------------
// Bytes arrive on the slave stream in the order Y0 U Y1 V, one byte per word,
// and are accepted at one word per cycle as long as the four-entry group queue
// has room. Each V byte yields two pixels on the master stream, the first from
// Y0 and the second from Y1, sharing U and V; m_tuser marks the second pixel
// and m_tlast marks the second pixel of a group whose V byte carried s_tlast.
// A slave tlast on any other byte drops the unfinished group and restarts the
// byte phase. The back end emits one pixel per cycle while the master side is
// ready, so a continuous byte stream (two pixels per four bytes) never backs
// up. The queue entry is written when the V byte is accepted; from the queue
// head the group stage registers the lumas and chroma products, and the
// output register then takes the first pixel and after it the second.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] stream_byte
    input  wire         s_tlast,    // frame_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_tuser,    // pair_last
    output logic        m_tlast     // frame_last
);
    import yuv2rgb_pkg::*;

    group_t push_data;
    group_t head_data;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_not_empty;

    // Byte collection.
    yuv2rgb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // Group queue.
    yuv2rgb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    // Color conversion and output.
    yuv2rgb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (head_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule : yuyv_to_rgb_converter
`default_nettype wire

### rtl/yuv2rgb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB front end
// Accepts stream bytes, tracks the byte phase and collects Y0, U and Y1;
// a complete group is pushed to the queue on the V byte.
// ----------------------------------------------------------------------------
module yuv2rgb_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,   // [7:0] stream_byte
    input  wire                  s_tlast,   // frame_end
    input  wire                  q_full,
    output logic                 q_push,
    output yuv2rgb_pkg::group_t  q_data
);
    import yuv2rgb_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] luma_first_reg;
    logic [7:0] chroma_blue_reg;
    logic [7:0] luma_second_reg;
    logic       accept;

    // Take a byte whenever the queue has room for a possible group.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // A V byte completes the group.
    assign q_push = accept && (phase_reg == PHASE_V);
    assign q_data = '{luma_first:  luma_first_reg,
                      luma_second: luma_second_reg,
                      chroma_blue: chroma_blue_reg,
                      chroma_red:  s_tdata,
                      frame_end:   s_tlast};

    // Frame end restarts the phase and drops any unfinished group.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (s_tlast) begin
                phase_next = PHASE_Y0;
            end else begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_Y0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Byte capture by phase.
    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (phase_reg)
                PHASE_Y0: luma_first_reg  <= s_tdata;
                PHASE_U:  chroma_blue_reg <= s_tdata;
                PHASE_Y1: luma_second_reg <= s_tdata;
                default: begin
                end
            endcase
        end
    end

endmodule : yuv2rgb_front
`default_nettype wire

### rtl/yuv2rgb_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB group queue
// Short first-in first-out queue of complete groups between front and back.
// ----------------------------------------------------------------------------
module yuv2rgb_fifo (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  yuv2rgb_pkg::group_t  push_data,
    output logic                 full,
    input  wire                  pop,
    output logic                 not_empty,
    output yuv2rgb_pkg::group_t  head_data
);
    import yuv2rgb_pkg::*;

    group_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : yuv2rgb_fifo
`default_nettype wire

### rtl/yuv2rgb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB back end
// Forms the shared chroma terms of a group, then emits its two pixels
// through a registered output word.
// ----------------------------------------------------------------------------
module yuv2rgb_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_not_empty,
    input  yuv2rgb_pkg::group_t  q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [23:0]          m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                 m_tuser,   // pair_last
    output logic                 m_tlast    // frame_last
);
    import yuv2rgb_pkg::*;

    // Clamp a scaled sum to 0..255 after truncation toward zero.
    function automatic logic [7:0] clamp_scaled(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (acc[ACC_W-2:COEF_FRAC_BITS+8] != '0) begin
            res = 8'd255;
        end else begin
            res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return res;
    endfunction

    logic signed [8:0]        du;
    logic signed [8:0]        dv;
    logic signed [TERM_W-1:0] r_prod, gu_prod, gv_prod, b_prod;

    // Group stage: lumas and shared chroma terms.
    logic                     grp_valid_reg;
    logic [7:0]               grp_y0_reg;
    logic [7:0]               grp_y1_reg;
    logic                     grp_fend_reg;
    logic signed [TERM_W-1:0] r_term_reg;
    logic signed [TERM_W-1:0] g_term_reg;
    logic signed [TERM_W-1:0] b_term_reg;
    logic                     sel_reg;

    logic                     out_load;
    logic                     grp_take;
    logic [7:0]               y_sel;
    logic signed [ACC_W-1:0]  y_scaled;
    logic signed [ACC_W-1:0]  r_acc, g_acc, b_acc;
    logic [7:0]               red_pix;
    logic [7:0]               green_pix;
    logic [7:0]               blue_pix;
    logic [23:0]              pix_word;

    // Chroma offsets and products from the queue head.
    assign du      = $signed({1'b0, q_data.chroma_blue}) - 9'sd128;
    assign dv      = $signed({1'b0, q_data.chroma_red}) - 9'sd128;
    assign r_prod  = $signed({1'b0, K_RV}) * dv;
    assign gu_prod = $signed({1'b0, K_GU}) * du;
    assign gv_prod = $signed({1'b0, K_GV}) * dv;
    assign b_prod  = $signed({1'b0, K_BU}) * du;

    // Handshake between queue, group stage and output word.
    assign out_load = grp_valid_reg && (!m_tvalid || m_tready);
    assign grp_take = !grp_valid_reg || (out_load && sel_reg);
    assign q_pop    = q_not_empty && grp_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end else begin
            if (grp_take) begin
                grp_valid_reg <= q_not_empty;
            end
            if (out_load) begin
                sel_reg <= !sel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            grp_y0_reg   <= q_data.luma_first;
            grp_y1_reg   <= q_data.luma_second;
            grp_fend_reg <= q_data.frame_end;
            r_term_reg   <= r_prod;
            g_term_reg   <= -(gu_prod + gv_prod);
            b_term_reg   <= b_prod;
        end
    end

    // Pixel sums: first pixel uses Y0, second uses Y1.
    assign y_sel    = sel_reg ? grp_y1_reg : grp_y0_reg;
    assign y_scaled = $signed({{(ACC_W-8-COEF_FRAC_BITS){1'b0}}, y_sel,
                               {COEF_FRAC_BITS{1'b0}}});
    assign r_acc    = y_scaled + ACC_W'(r_term_reg);
    assign g_acc    = y_scaled + ACC_W'(g_term_reg);
    assign b_acc    = y_scaled + ACC_W'(b_term_reg);

    // Clamped color bytes packed into one stream word.
    assign red_pix   = clamp_scaled(r_acc);
    assign green_pix = clamp_scaled(g_acc);
    assign blue_pix  = clamp_scaled(b_acc);

    yuv2rgb_pix_fmt u_pix_fmt (
        .red      (red_pix),
        .green    (green_pix),
        .blue     (blue_pix),
        .pix_word (pix_word)
    );

    // Output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= pix_word;
            m_tuser <= sel_reg;
            m_tlast <= sel_reg && grp_fend_reg;
        end
    end

endmodule : yuv2rgb_back
`default_nettype wire

### rtl/yuv_to_rgb_converter_top_placeholder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to RGB pixel formatter
// Packs the three color bytes of one pixel into a stream word.
// ----------------------------------------------------------------------------
module yuv2rgb_pix_fmt (
    input  wire  [7:0]  red,
    input  wire  [7:0]  green,
    input  wire  [7:0]  blue,
    output logic [23:0] pix_word     // [7:0] red, [15:8] green, [23:16] blue
);
    // Lowest byte first: red, then green, then blue.
    assign pix_word = {blue, green, red};

endmodule : yuv2rgb_pix_fmt
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter testbench
// Streams packed YUYV bytes into the converter with random gaps on both
// sides. It predicts every RGB pixel with its own full-range BT.601 model and
// compares each pixel on the master stream with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import yuv2rgb_pkg::*;

    localparam int    RANDOM_BYTES = 1200;
    localparam int    STEADY_BYTES = 220;
    localparam int    DRAIN_CYCLES = 24;
    localparam int    CYCLE_LIMIT  = 1000000;

    // Fixed-point color coefficients, rounded to nearest from units of 1e-5.
    localparam longint ONE_Q = longint'(1) <<< COEF_FRAC_BITS;
    localparam longint CR_V  = (longint'(140200) * ONE_Q + 50000) / 100000;
    localparam longint CG_U  = (longint'(34414) * ONE_Q + 50000) / 100000;
    localparam longint CG_V  = (longint'(71414) * ONE_Q + 50000) / 100000;
    localparam longint CB_U  = (longint'(177200) * ONE_Q + 50000) / 100000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pair_last;
        logic       frame_last;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] stream_byte
    logic        s_tlast;    // frame_end
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] red, [15:8] green, [23:16] blue
    logic        m_tuser;    // pair_last
    logic        m_tlast;    // frame_last

    // Model state: byte position in the group and the held Y0, U and Y1.
    logic [1:0]  group_phase;
    logic [7:0]  held_y0;
    logic [7:0]  held_u;
    logic [7:0]  held_y1;

    pixel_t      pending_pixels[$];
    int          mismatches;
    int          pixels_seen;
    int          bytes_sent;
    int          cycle_count;
    bit          no_idle;

    yuyv_to_rgb_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation, 8 ns period.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("FAIL yuyv_to_rgb_converter");
            $finish;
        end
    end

    // Divide by 2^F toward zero, then saturate to one byte.
    function automatic logic [7:0] clamp_byte(input longint acc);
        longint q;
        q = acc / ONE_Q;
        if (q < 0)
            return 8'd0;
        if (q > 255)
            return 8'd255;
        return q[7:0];
    endfunction

    function automatic pixel_t convert_pixel(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, input logic second,
                                             input logic last);
        pixel_t px;
        longint luma;
        longint du;
        longint dv;
        luma = longint'(y) * ONE_Q;
        du = longint'(u) - 128;
        dv = longint'(v) - 128;
        px.red        = clamp_byte(luma + CR_V * dv);
        px.green      = clamp_byte(luma - CG_U * du - CG_V * dv);
        px.blue       = clamp_byte(luma + CB_U * du);
        px.pair_last  = second;
        px.frame_last = last;
        return px;
    endfunction

    // Advance the model by one accepted byte and queue any pixels it yields.
    task automatic predict_byte(input logic [7:0] b, input logic fend);
        case (group_phase)
            PHASE_Y0: held_y0 = b;
            PHASE_U:  held_u = b;
            PHASE_Y1: held_y1 = b;
            PHASE_V: begin
                pending_pixels.push_back(convert_pixel(held_y0, held_u, b, 1'b0, 1'b0));
                pending_pixels.push_back(convert_pixel(held_y1, held_u, b, 1'b1, fend));
            end
        endcase
        group_phase = fend ? PHASE_Y0 : group_phase + 2'd1;
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Random byte with a bias toward the range ends and the chroma midpoint.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0: return 8'd0;
                1: return 8'd255;
                2: return 8'd128;
                3: return 8'd1;
                4: return 8'd254;
                default: return 8'd127;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one word; returns at the edge where it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic fend);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fend;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_byte(b, fend);
        bytes_sent++;
    endtask

    task automatic send_group(input logic [7:0] y0, input logic [7:0] u,
                              input logic [7:0] y1, input logic [7:0] v,
                              input logic fend);
        send_byte(y0, 1'b0);
        send_byte(u, 1'b0);
        send_byte(y1, 1'b0);
        send_byte(v, fend);
    endtask

    // A frame of random groups; a broken frame ends early on Y0, U or Y1.
    task automatic send_frame(input int groups, input bit broken);
        int cut;
        for (int g = 0; g < groups - 1; g++)
            send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 1'b0);
        if (broken) begin
            cut = $urandom_range(0, 2);
            for (int k = 0; k < cut; k++)
                send_byte(pick_byte(), 1'b0);
            send_byte(pick_byte(), 1'b1);
        end else begin
            send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 1'b1);
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("pixel %0d: %s is %0d, expected %0d", pixels_seen, field, got, want);
    endtask

    // Compare every accepted pixel with the oldest prediction.
    always @(posedge aclk) begin : check_pixels
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unpredicted pixel, tdata", m_tdata, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red", m_tdata[7:0], want.red);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green", m_tdata[15:8], want.green);
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue", m_tdata[23:16], want.blue);
                if (m_tuser !== want.pair_last)
                    report_mismatch("pair_last", m_tuser, want.pair_last);
                if (m_tlast !== want.frame_last)
                    report_mismatch("frame_last", m_tlast, want.frame_last);
            end
            pixels_seen++;
        end
    end

    // Master side back-pressure: ready runs broken by random stalls.
    initial begin
        int run;
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            run = no_idle ? 1 : $urandom_range(1, 24);
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Full-scale luma and chroma corners, all clamp directions.
    task automatic test_color_extremes();
        send_group(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
        send_group(8'd255, 8'd255, 8'd0, 8'd255, 1'b0);
        send_group(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
        send_group(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
    endtask

    // Frame end on each byte position: Y0, U and Y1 drop the group, V ends it.
    task automatic test_frame_end_positions();
        send_byte(8'd200, 1'b1);
        send_byte(8'd10, 1'b0);
        send_byte(8'd20, 1'b1);
        send_byte(8'd30, 1'b0);
        send_byte(8'd40, 1'b0);
        send_byte(8'd50, 1'b1);
        send_group(8'd16, 8'd0, 8'd235, 8'd255, 1'b1);
    endtask

    // Random frames of mostly short length; about one in ten ends mid-group.
    task automatic test_random_frames();
        int start;
        int groups;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            groups = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
            send_frame(groups, $urandom_range(0, 9) == 0);
        end
    endtask

    // Continuous stream with the master always ready: the block must not stall.
    task automatic test_back_to_back();
        int start;
        start = bytes_sent;
        no_idle = 1'b1;
        while (bytes_sent - start < STEADY_BYTES)
            send_frame($urandom_range(2, 12), $urandom_range(0, 7) == 0);
        no_idle = 1'b0;
    endtask

    // Reset, stimulus and verdict.
    initial begin
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'd0;
        s_tlast     <= 1'b0;
        aresetn     <= 1'b0;
        cycle_count  = 0;
        mismatches   = 0;
        pixels_seen  = 0;
        bytes_sent   = 0;
        no_idle      = 1'b0;
        group_phase  = PHASE_Y0;
        held_y0      = 8'd0;
        held_u       = 8'd0;
        held_y1      = 8'd0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_color_extremes();
        test_frame_end_positions();
        test_random_frames();
        test_back_to_back();

        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("PASS yuyv_to_rgb_converter");
        else
            $display("FAIL yuyv_to_rgb_converter");
        $finish;
    end

endmodule
